// ===== rtl/sorted_timeout_queue_top_assert.svh =====
// Assertion macros for the sorted timeout queue.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef SORTED_TIMEOUT_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_TOP_ASSERT_SVH

// Condition c holds in the same cycle as a.
`define STQ_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("stq check failed");

// Condition c holds in the cycle after a.
`define STQ_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("stq check failed");

`endif

// ===== rtl/stq_pkg.sv =====
package stq_pkg;

  // Fixed field widths
  localparam int SEC_W   = 32;
  localparam int TPS_W   = 7;
  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 2;
  localparam int RC_W    = 5;
  localparam int HOUT_W  = 16;

  // Expiries delivered per second boundary at most
  localparam int MAX_OUT = 16;
  localparam int POP_W   = $clog2(MAX_OUT);

  localparam logic [TPS_W-1:0] TPS_RESET = 7'd50;
  localparam logic [RC_W-1:0]  RC_MAX    = 5'd31;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSTALL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSTALLED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVED   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EXPIRE,
    ST_REMOVE,
    ST_RDONE
  } state_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load;
  } cell_ctrl_t;

endpackage

// ===== rtl/stq_cell.sv =====
module stq_cell import stq_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [SEC_W-1:0]       bus_deadline,
  input  logic [HANDLE_BITS-1:0] bus_handle,
  input  logic                   prev_ge,
  input  logic                   left_valid,
  input  logic [SEC_W-1:0]       left_deadline,
  input  logic [HANDLE_BITS-1:0] left_handle,
  input  logic                   right_valid,
  input  logic [SEC_W-1:0]       right_deadline,
  input  logic [HANDLE_BITS-1:0] right_handle,
  output logic                   valid,
  output logic [SEC_W-1:0]       deadline,
  output logic [HANDLE_BITS-1:0] handle,
  output logic                   ge
);

  logic                   valid_next;
  logic [SEC_W-1:0]       deadline_next;
  logic [HANDLE_BITS-1:0] handle_next;

  // Empty cells and equal or later deadlines sit behind a new entry
  assign ge = !valid || (deadline >= bus_deadline);

  always_comb begin
    valid_next    = valid;
    deadline_next = deadline;
    handle_next   = handle;
    case (ctrl.op)
      OP_SHIFT: begin
        // move one place toward the head, or take the bus item
        if (ctrl.load) begin
          valid_next    = 1'b1;
          deadline_next = bus_deadline;
          handle_next   = bus_handle;
        end else begin
          valid_next    = right_valid;
          deadline_next = right_deadline;
          handle_next   = right_handle;
        end
      end
      OP_INSERT: begin
        // first cell at or past the new deadline takes it, the rest move back
        if (ge && !prev_ge) begin
          valid_next    = 1'b1;
          deadline_next = bus_deadline;
          handle_next   = bus_handle;
        end else if (ge) begin
          valid_next    = left_valid;
          deadline_next = left_deadline;
          handle_next   = left_handle;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= deadline_next;
    handle   <= handle_next;
  end

endmodule

// ===== rtl/sorted_timeout_queue_top.sv =====
// Sorted timeout queue.
// Input channel (in_valid/in_ready) takes func, handle and offset. A tick item
// counts the tick divider down; on reload the seconds clock advances and every
// due entry comes out on the result channel (out_valid/out_ready), earliest
// deadline first, at most 16 per second, last set on the final one. An install
// item gives one result (accepted, or refused when the table is full); a remove
// item gives one result carrying the number of entries deleted.
// cfg_valid/cfg_data writes ticks_per_second; cfg_ready is always high.
// Flow: a tick that does not reload stays idle; a reloading tick goes to the
// expire state, one result per due entry; install goes to the insert state;
// remove scans, then gives its result, and the scan rotates the whole cell
// chain past its head one place per cycle.
// Entries live in a chain of QUEUE_DEPTH cells kept in deadline order; insert
// is one parallel compare and shift across the chain.
// The result register holds its item while out_ready is low; one more input
// item with a result is taken meanwhile, waiting for the register to free up;
// non-reloading ticks go on being taken. Reset (rst, synchronous) empties the
// table, clears the clock and sets the tick divider to 50.
`include "sorted_timeout_queue_top_assert.svh"

module sorted_timeout_queue_top import stq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [15:0]       handle,
  input  logic [15:0]       offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] kind,
  output logic [HOUT_W-1:0] handle_out,
  output logic [RC_W-1:0]   removed_count,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TPS_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  state_t                 state;
  state_t                 state_next;
  logic [TPS_W-1:0]       ticks_per_second;
  logic [TPS_W-1:0]       ticks_left;
  logic [SEC_W-1:0]       seconds_now;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       remaining;
  logic [IDX_W-1:0]       wr_idx;
  logic [RC_W-1:0]        gone;
  logic [POP_W-1:0]       popped;
  logic [HANDLE_BITS-1:0] op_handle;
  logic [SEC_W-1:0]       ins_deadline;

  // Cell chain
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [SEC_W-1:0]       cell_deadline [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  cell_ctrl_t             cell_ctrl     [QUEUE_DEPTH];

  // Control outputs of the sequencer
  cell_op_t               cell_op;
  logic                   load_en;
  logic [SEC_W-1:0]       bus_deadline;
  logic [HANDLE_BITS-1:0] bus_handle;
  logic                   emit;
  logic [KIND_W-1:0]      res_kind;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [RC_W-1:0]        res_count;
  logic                   res_last;

  logic in_fire;
  logic out_free;
  logic tick_wrap;
  logic full;
  logic head_exp;
  logic next_exp;
  logic exp_last;
  logic keep;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign tick_wrap = (ticks_left <= TPS_W'(1));
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign head_exp  = cell_valid[0] && (cell_deadline[0] <= seconds_now);
  assign next_exp  = cell_valid[1] && (cell_deadline[1] <= seconds_now);
  assign exp_last  = !next_exp || (popped == POP_W'(MAX_OUT - 1));
  assign keep      = (cell_handle[0] != op_handle);

  // Chain of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   left_valid;
    logic [SEC_W-1:0]       left_deadline;
    logic [HANDLE_BITS-1:0] left_handle;
    logic                   left_ge;
    logic                   right_valid;
    logic [SEC_W-1:0]       right_deadline;
    logic [HANDLE_BITS-1:0] right_handle;

    if (i == 0) begin : g_head
      assign left_valid    = 1'b0;
      assign left_deadline = '0;
      assign left_handle   = '0;
      assign left_ge       = 1'b0;
    end else begin : g_body
      assign left_valid    = cell_valid[i-1];
      assign left_deadline = cell_deadline[i-1];
      assign left_handle   = cell_handle[i-1];
      assign left_ge       = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_valid    = 1'b0;
      assign right_deadline = '0;
      assign right_handle   = '0;
    end else begin : g_mid
      assign right_valid    = cell_valid[i+1];
      assign right_deadline = cell_deadline[i+1];
      assign right_handle   = cell_handle[i+1];
    end

    assign cell_ctrl[i].op   = cell_op;
    assign cell_ctrl[i].load = load_en && (wr_idx == IDX_W'(i));

    stq_cell #(
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (cell_ctrl[i]),
      .bus_deadline   (bus_deadline),
      .bus_handle     (bus_handle),
      .prev_ge        (left_ge),
      .left_valid     (left_valid),
      .left_deadline  (left_deadline),
      .left_handle    (left_handle),
      .right_valid    (right_valid),
      .right_deadline (right_deadline),
      .right_handle   (right_handle),
      .valid          (cell_valid[i]),
      .deadline       (cell_deadline[i]),
      .handle         (cell_handle[i]),
      .ge             (cell_ge[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (func)
            FUNC_TICK:    state_next = tick_wrap ? ST_EXPIRE : ST_IDLE;
            FUNC_INSTALL: state_next = ST_INSERT;
            FUNC_REMOVE:  state_next = ST_REMOVE;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_EXPIRE: begin
        if (!head_exp) begin
          state_next = ST_IDLE;
        end else if (out_free && exp_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        if (remaining == '0) begin
          state_next = ST_RDONE;
        end
      end
      ST_RDONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: chain command and result
  always_comb begin
    cell_op      = OP_HOLD;
    load_en      = 1'b0;
    bus_deadline = ins_deadline;
    bus_handle   = op_handle;
    emit         = 1'b0;
    res_kind     = KIND_EXPIRED;
    res_handle   = cell_handle[0];
    res_count    = '0;
    res_last     = 1'b1;
    case (state)
      ST_INSERT: begin
        if (out_free) begin
          emit       = 1'b1;
          res_handle = op_handle;
          if (full) begin
            res_kind = KIND_FULL;
          end else begin
            res_kind = KIND_INSTALLED;
            cell_op  = OP_INSERT;
          end
        end
      end
      ST_EXPIRE: begin
        // pop the head, one result per cycle while the result register is free
        if (head_exp && out_free) begin
          cell_op  = OP_SHIFT;
          emit     = 1'b1;
          res_last = exp_last;
        end
      end
      ST_REMOVE: begin
        // rotate the head out; kept entries go back behind the unscanned ones
        if (remaining != '0) begin
          cell_op      = OP_SHIFT;
          bus_deadline = cell_deadline[0];
          bus_handle   = cell_handle[0];
          load_en      = keep;
        end
      end
      ST_RDONE: begin
        if (out_free) begin
          emit       = 1'b1;
          res_kind   = KIND_REMOVED;
          res_handle = op_handle;
          res_count  = gone;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ticks_per_second <= TPS_RESET;
      ticks_left       <= TPS_RESET;
      seconds_now      <= '0;
      count            <= '0;
      remaining        <= '0;
      wr_idx           <= '0;
      gone             <= '0;
      popped           <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        ticks_per_second <= cfg_data;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            remaining <= count;
            wr_idx    <= IDX_W'(count - CNT_W'(1));
            gone      <= '0;
            popped    <= '0;
            if (func == FUNC_TICK) begin
              if (tick_wrap) begin
                ticks_left  <= (ticks_per_second == '0) ? TPS_W'(1) : ticks_per_second;
                seconds_now <= seconds_now + SEC_W'(1);
              end else begin
                ticks_left <= ticks_left - TPS_W'(1);
              end
            end
          end
        end
        ST_INSERT: begin
          if (out_free && !full) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_EXPIRE: begin
          if (emit) begin
            count  <= count - CNT_W'(1);
            popped <= popped + POP_W'(1);
          end
        end
        ST_REMOVE: begin
          if (remaining != '0) begin
            remaining <= remaining - CNT_W'(1);
            if (!keep) begin
              wr_idx <= wr_idx - IDX_W'(1);
              count  <= count - CNT_W'(1);
              if (gone != RC_MAX) begin
                gone <= gone + RC_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_handle    <= HANDLE_BITS'(handle);
      ins_deadline <= seconds_now + SEC_W'(offset);
    end
    if (emit) begin
      kind          <= res_kind;
      handle_out    <= HOUT_W'(res_handle);
      removed_count <= res_count;
      last          <= res_last;
    end
  end

  // Valid cells always form an unbroken run from the head
  `STQ_ASSERT_NOW(a_valid_run, 1'b1, (cell_valid & (cell_valid + QUEUE_DEPTH'(1))) == '0)

  // Fill count tracks the valid cells
  `STQ_ASSERT_NOW(a_count_match, 1'b1, $countones(cell_valid) == count)

  // A non-final expiry leaves another due entry at the head
  `STQ_ASSERT_NEXT(a_expire_more, emit && (state == ST_EXPIRE) && !res_last, head_exp)

endmodule

// ===== dv/sorted_timeout_queue_top_test.sv =====
`timescale 1ns / 1ps

module sorted_timeout_queue_top_test;
  import stq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 32;

  // func 3 has no meaning; the block must drop it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Handles reused often so removes find something
  localparam logic [15:0] HANDLE_POOL [8] = '{
    16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5A5A, 16'h0001, 16'h8000, 16'h1234
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HOUT_W-1:0] id;
    logic [RC_W-1:0]   removed;
    logic              last;
  } timeout_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func = FUNC_TICK;
  logic [15:0]       handle = '0;
  logic [15:0]       offset = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [HOUT_W-1:0] handle_out;
  logic [RC_W-1:0]   removed_count;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TPS_W-1:0]  cfg_data = '0;

  // Predicted state of the timeout table
  logic [SEC_W-1:0]  clk_seconds;
  logic [TPS_W-1:0]  rate;
  logic [TPS_W-1:0]  tick_countdown;
  logic [SEC_W-1:0]  slot_deadline [DEPTH];
  logic [15:0]       slot_handle [DEPTH];
  int                slot_count;
  timeout_result_t   pending_results [$];

  int tx_gap_max  = 18;
  int rx_wait_max = 18;
  int hold_cycles = 0;
  int items_sent = 0, results_seen = 0, rate_writes = 0;
  int expiries_seen = 0, refusals_seen = 0;
  int mismatches = 0, errors = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_timeout_queue_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .handle       (handle),
    .offset       (offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .handle_out   (handle_out),
    .removed_count(removed_count),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  function automatic void expect_result(logic [KIND_W-1:0] k, logic [15:0] h,
                                        logic [RC_W-1:0] rc, logic l);
    timeout_result_t r;
    r.kind    = k;
    r.id      = h;
    r.removed = rc;
    r.last    = l;
    pending_results.push_back(r);
  endfunction

  // Update the table for one accepted item and queue the results it causes
  function automatic void predict_item(logic [FUNC_W-1:0] f, logic [15:0] h,
                                       logic [15:0] off);
    int n_due;
    int pos;
    int kept;
    int gone;
    int i;
    logic [SEC_W-1:0] due_at;
    case (f)
      FUNC_TICK: begin
        if (tick_countdown > 1) begin
          tick_countdown = tick_countdown - 1'b1;
        end else begin
          // reload; a rate of zero behaves as one
          tick_countdown = (rate == '0) ? TPS_W'(1) : rate;
          clk_seconds = clk_seconds + 1'b1;
          n_due = 0;
          while (n_due < slot_count && n_due < MAX_OUT &&
                 slot_deadline[n_due] <= clk_seconds)
            n_due++;
          for (i = 0; i < n_due; i++)
            expect_result(KIND_EXPIRED, slot_handle[i], '0, i == n_due - 1);
          for (i = n_due; i < slot_count; i++) begin
            slot_deadline[i - n_due] = slot_deadline[i];
            slot_handle[i - n_due]   = slot_handle[i];
          end
          slot_count -= n_due;
        end
      end
      FUNC_INSTALL: begin
        due_at = clk_seconds + SEC_W'(off);
        if (slot_count >= DEPTH) begin
          expect_result(KIND_FULL, h, '0, 1'b1);
        end else begin
          // newest goes ahead of equal deadlines
          pos = 0;
          while (pos < slot_count && slot_deadline[pos] < due_at)
            pos++;
          for (i = slot_count; i > pos; i--) begin
            slot_deadline[i] = slot_deadline[i - 1];
            slot_handle[i]   = slot_handle[i - 1];
          end
          slot_deadline[pos] = due_at;
          slot_handle[pos]   = h;
          slot_count++;
          expect_result(KIND_INSTALLED, h, '0, 1'b1);
        end
      end
      FUNC_REMOVE: begin
        kept = 0;
        gone = 0;
        for (i = 0; i < slot_count; i++) begin
          if (slot_handle[i] == h) begin
            gone++;
          end else begin
            slot_deadline[kept] = slot_deadline[i];
            slot_handle[kept]   = slot_handle[i];
            kept++;
          end
        end
        slot_count = kept;
        expect_result(KIND_REMOVED, h, (gone > RC_MAX) ? RC_MAX : RC_W'(gone), 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Offer one item after a random gap; valid stays up across back-to-back items
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [15:0] h,
                           input logic [15:0] off);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    handle   <= h;
    offset   <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(f, h, off);
    items_sent++;
  endtask

  // Stop offering, let every expected result arrive, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [TPS_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rate = v;
    rate_writes++;
  endtask

  // Tick until the divider reloads once
  task automatic tick_to_boundary();
    while (tick_countdown > 1)
      send_item(FUNC_TICK, 16'($urandom), 16'($urandom));
    send_item(FUNC_TICK, 16'($urandom), 16'($urandom));
  endtask

  // Field extremes and every operation at the reset rate, then a run-down of
  // the 50-tick divider; the rate written meanwhile waits for the reload
  task automatic test_reset_rate();
    send_item(FUNC_INSTALL, 16'h0000, 16'h0000);
    send_item(FUNC_INSTALL, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_REMOVE, 16'h1234, 16'hFFFF);
    send_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_TICK, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_REMOVE, 16'hFFFF, 16'h0000);
    write_rate(7'd0);
    tick_to_boundary();
  endtask

  // Deadline order, newest first among equal deadlines, and an idle tick
  task automatic test_expiry_order();
    send_item(FUNC_INSTALL, 16'h1111, 16'd2);
    send_item(FUNC_INSTALL, 16'h2222, 16'd1);
    send_item(FUNC_INSTALL, 16'h3333, 16'd1);
    send_item(FUNC_INSTALL, 16'h4444, 16'd2);
    send_item(FUNC_INSTALL, 16'h5555, 16'd0);
    send_item(FUNC_INSTALL, 16'h6666, 16'd3);
    repeat (4) tick_to_boundary();
  endtask

  // Fill the table, get a refusal, then remove a handle stored many times
  task automatic test_full_table();
    int i;
    write_rate(7'd127);
    for (i = 0; i < 10; i++)
      send_item(FUNC_INSTALL, 16'hA5A5, 16'hFFFF);
    for (i = 0; i < 6; i++)
      send_item(FUNC_INSTALL, HANDLE_POOL[i], 16'(i * 1000 + 7));
    send_item(FUNC_INSTALL, 16'hC3C3, 16'h0001);
    send_item(FUNC_REMOVE, 16'hA5A5, 16'h0000);
    send_item(FUNC_REMOVE, 16'hC3C3, 16'h0000);
    while (slot_count > 0)
      send_item(FUNC_REMOVE, slot_handle[0], 16'($urandom));
  endtask

  // A full table all due on the same second
  task automatic test_mass_expiry();
    int i;
    write_rate(7'd1);
    for (i = 0; i < DEPTH; i++)
      send_item(FUNC_INSTALL, 16'(i * 4099 + 3), 16'(i % 2));
    tick_to_boundary();
    tick_to_boundary();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int i;
    write_rate(7'd2);
    tx_gap_max  = 0;
    hold_cycles = HOLD_CYCLES;
    for (i = 0; i < 40; i++) begin
      case (i % 4)
        0, 1:    send_item(FUNC_INSTALL, HANDLE_POOL[$urandom_range(7, 0)],
                           16'($urandom_range(2, 0)));
        2:       send_item(FUNC_REMOVE, HANDLE_POOL[$urandom_range(7, 0)], 16'($urandom));
        default: send_item(FUNC_TICK, 16'($urandom), 16'($urandom));
      endcase
    end
    tx_gap_max = 18;
  endtask

  // Random traffic over a series of rates, idling on and off
  task automatic test_random_traffic();
    logic [TPS_W-1:0] rates [10];
    logic [FUNC_W-1:0] f;
    logic [15:0] h;
    logic [15:0] off;
    int p;
    int n;
    int pick;
    int sub;
    rates = '{TPS_RESET, 7'd1, 7'd3, 7'd0, 7'd100, 7'd127, 7'd2, 7'd4, 7'd1, 7'd0};
    rates[8] = TPS_W'($urandom_range(8, 1));
    rates[9] = TPS_W'($urandom_range(127, 0));
    for (p = 0; p < 10; p++) begin
      write_rate(rates[p]);
      tx_gap_max  = (p % 3 == 2) ? 0 : 18;
      rx_wait_max = (p % 3 == 2) ? 0 : 18;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99, 0);
        sub  = $urandom_range(19, 0);
        h    = 16'($urandom);
        off  = 16'($urandom);
        if (pick < 50) begin
          f = FUNC_TICK;
        end else if (pick < 75) begin
          f = FUNC_INSTALL;
          if (sub % 4 != 0) h = HANDLE_POOL[$urandom_range(7, 0)];
          // mostly short timeouts so they expire within the phase
          if (sub < 14) off = 16'($urandom_range(3, 0));
          else if (sub < 17) off = 16'($urandom_range(40, 0));
        end else if (pick < 95) begin
          f = FUNC_REMOVE;
          if (sub < 10 && slot_count > 0) h = slot_handle[$urandom_range(slot_count - 1, 0)];
          else if (sub < 16) h = HANDLE_POOL[$urandom_range(7, 0)];
        end else begin
          f = FUNC_UNUSED;
        end
        send_item(f, h, off);
      end
    end
    tx_gap_max  = 18;
    rx_wait_max = 18;
  endtask

  // Result side: random ready gaps, one long hold when asked, compare in order
  initial begin : result_check
    int w;
    timeout_result_t seen;
    timeout_result_t want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        w = hold_cycles;
        hold_cycles = 0;
      end else begin
        w = $urandom_range(rx_wait_max, 0);
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && hold_cycles == 0) @(posedge clk);
      if (out_valid) begin
        seen = {kind, handle_out, removed_count, last};
        results_seen++;
        if (kind == KIND_EXPIRED) expiries_seen++;
        if (kind == KIND_FULL) refusals_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: kind %0d handle %h count %0d last %0b",
                     seen.kind, seen.id, seen.removed, seen.last);
        end else begin
          want = pending_results.pop_front();
          if (seen.kind != want.kind || seen.id != want.id ||
              seen.removed != want.removed || seen.last != want.last) begin
            errors++;
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: want %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                       want.kind, want.id, want.removed, want.last,
                       seen.kind, seen.id, seen.removed, seen.last);
          end
        end
      end
    end
  end

  // Watchdog: too long with no item moving on any channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : run
    clk_seconds    = '0;
    rate           = TPS_RESET;
    tick_countdown = TPS_RESET;
    slot_count     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_rate();
    test_expiry_order();
    test_full_table();
    test_mass_expiry();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("covered %0d items and %0d results: %0d expiries, %0d refused installs",
             items_sent, results_seen, expiries_seen, refusals_seen);
    $display("tick rate written %0d times over 0 to 127, with one long output stall",
             rate_writes);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sorted_timeout_queue_top.f =====
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timeout_queue_top.sv
dv/sorted_timeout_queue_top_test.sv
